### design/wsfe_pkg.sv
// ----------------------------------------------------------------------------
// wsfe_pkg
// Shared types and constants of the websocket frame encoder: field widths,
// request codes, error codes and the byte job passed from front to back.
// ----------------------------------------------------------------------------
package wsfe_pkg;

    // field widths
    localparam int LEN_W  = 63;
    localparam int KEY_W  = 32;
    localparam int ERR_W  = 3;

    // longest byte job: header, length code, 8 length bytes, 4 key bytes
    localparam int JOB_BYTES = 14;
    localparam int JOB_W     = JOB_BYTES * 8;
    localparam int CNT_W     = $clog2(JOB_BYTES + 1);

    // default depth of the job queue
    localparam int QUEUE_DEPTH = 2;

    // request kinds
    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_PAYLOAD = 1'b1;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_RSV       = 3'd1;
    localparam logic [ERR_W-1:0] ERR_OPCODE    = 3'd2;
    localparam logic [ERR_W-1:0] ERR_CTRL_LEN  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_CTRL_FRAG = 3'd4;
    localparam logic [ERR_W-1:0] ERR_STRAY     = 3'd5;

    // header constants
    localparam logic [3:0] OP_FIELD_BITS = 4'h0F;
    localparam logic [3:0] OP_BINARY     = 4'd2;
    localparam logic [3:0] OP_CLOSE      = 4'd8;
    localparam logic [3:0] OP_PONG       = 4'd10;
    localparam logic [6:0] LEN7_MAX      = 7'd125;
    localparam logic [6:0] LEN16_CODE    = 7'd126;
    localparam logic [6:0] LEN64_CODE    = 7'd127;

    // one unit of work for the byte serializer
    typedef struct packed {
        logic [JOB_W-1:0] bytes;     // first wire byte in the top bits
        logic [CNT_W-1:0] count;     // number of bytes, 1 to JOB_BYTES
        logic             frame_end; // last byte closes the frame
        logic [ERR_W-1:0] err;
    } t_job;

endpackage

### design/wsfe_if.sv
// ----------------------------------------------------------------------------
// wsfe_if
// Valid/ready channels of the frame encoder: request input and byte output.
// ----------------------------------------------------------------------------
interface wsfe_in_if;
    import wsfe_pkg::*;

    logic             valid;
    logic             ready;
    logic             func;
    logic [7:0]       header_byte;
    logic             masked;
    logic [KEY_W-1:0] mask_key;
    logic [LEN_W-1:0] payload_length;
    logic [7:0]       payload_byte;

    modport source (
        output valid, func, header_byte, masked, mask_key, payload_length, payload_byte,
        input  ready
    );
    modport sink (
        input  valid, func, header_byte, masked, mask_key, payload_length, payload_byte,
        output ready
    );
endinterface

interface wsfe_out_if;
    import wsfe_pkg::*;

    logic             valid;
    logic             ready;
    logic [7:0]       out_byte;
    logic             last;
    logic             frame_end;
    logic [ERR_W-1:0] error;

    modport source (
        output valid, out_byte, last, frame_end, error,
        input  ready
    );
    modport sink (
        input  valid, out_byte, last, frame_end, error,
        output ready
    );
endinterface

### design/wsfe_front.sv
// ----------------------------------------------------------------------------
// wsfe_front
// Accepts requests, checks headers, tracks the open frame and masks payload
// bytes; turns each request into one byte job for the queue.
// ----------------------------------------------------------------------------
module wsfe_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wsfe_in_if.sink       i_in,
    output logic          o_push_valid,
    input  logic          i_push_ready,
    output wsfe_pkg::t_job o_push_job
);
    import wsfe_pkg::*;

    // frame state
    logic             r_frame_open, n_frame_open;
    logic [LEN_W-1:0] r_bytes_left, n_bytes_left;
    logic [KEY_W-1:0] r_key_store,  n_key_store;
    logic             r_mask_on,    n_mask_on;
    logic [1:0]       r_key_phase,  n_key_phase;

    logic             accept;
    logic [3:0]       opcode;
    logic             is_ctrl;
    logic             op_ok;
    logic             len_short;
    logic             len_wide;
    logic [ERR_W-1:0] start_err;
    logic [KEY_W-1:0] key_sel;
    logic [KEY_W-1:0] key_shift;
    logic [7:0]       len_code;
    logic [LEN_W-1:0] left_dec;
    t_job             job;

    assign i_in.ready   = i_push_ready;
    assign accept       = i_in.valid && i_push_ready;
    assign o_push_valid = i_in.valid;
    assign o_push_job   = job;

    // header classification
    assign opcode    = i_in.header_byte[3:0] & OP_FIELD_BITS;
    assign is_ctrl   = opcode[3];
    assign op_ok     = (opcode <= OP_BINARY) || ((opcode >= OP_CLOSE) && (opcode <= OP_PONG));
    assign len_short = (i_in.payload_length <= LEN_W'(LEN7_MAX));
    assign len_wide  = |i_in.payload_length[LEN_W-1:16];

    always_comb begin
        priority if (i_in.header_byte[6:4] != 3'b000) begin
            start_err = ERR_RSV;
        end else if (!op_ok) begin
            start_err = ERR_OPCODE;
        end else if (is_ctrl && !len_short) begin
            start_err = ERR_CTRL_LEN;
        end else if (is_ctrl && !i_in.header_byte[7]) begin
            start_err = ERR_CTRL_FRAG;
        end else begin
            start_err = ERR_NONE;
        end
    end

    // key byte for the current payload index, first byte in the top bits
    assign key_shift = r_key_store >> {~r_key_phase, 3'b000};
    assign key_sel   = i_in.masked ? i_in.mask_key : '0;
    assign left_dec  = r_bytes_left - LEN_W'(1);

    // second header byte: mask bit and length or length code
    always_comb begin
        priority if (len_wide) begin
            len_code = {i_in.masked, LEN64_CODE};
        end else if (!len_short) begin
            len_code = {i_in.masked, LEN16_CODE};
        end else begin
            len_code = {i_in.masked, i_in.payload_length[6:0]};
        end
    end

    // next state and job
    always_comb begin
        n_frame_open = r_frame_open;
        n_bytes_left = r_bytes_left;
        n_key_store  = r_key_store;
        n_mask_on    = r_mask_on;
        n_key_phase  = r_key_phase;
        job          = '0;
        job.count    = CNT_W'(1);

        if (i_in.func == FUNC_PAYLOAD) begin
            if (!r_frame_open) begin
                job.err = ERR_STRAY;
            end else begin
                job.bytes[JOB_W-1 -: 8] = r_mask_on ? (i_in.payload_byte ^ key_shift[7:0])
                                                    : i_in.payload_byte;
                job.frame_end = (left_dec == '0);
                n_bytes_left  = left_dec;
                n_key_phase   = r_key_phase + 2'd1;
                n_frame_open  = (left_dec != '0);
            end
        end else begin
            n_frame_open = 1'b0;
            n_bytes_left = '0;
            n_key_phase  = 2'd0;
            if (start_err != ERR_NONE) begin
                job.err = start_err;
            end else begin
                n_mask_on     = i_in.masked;
                n_key_store   = key_sel;
                n_frame_open  = (i_in.payload_length != '0);
                n_bytes_left  = i_in.payload_length;
                job.frame_end = (i_in.payload_length == '0);
                priority if (len_wide) begin
                    job.bytes = {i_in.header_byte, len_code, 1'b0, i_in.payload_length,
                                 key_sel};
                    job.count = i_in.masked ? CNT_W'(14) : CNT_W'(10);
                end else if (!len_short) begin
                    job.bytes = {i_in.header_byte, len_code, i_in.payload_length[15:0],
                                 key_sel, 48'd0};
                    job.count = i_in.masked ? CNT_W'(8) : CNT_W'(4);
                end else begin
                    job.bytes = {i_in.header_byte, len_code, key_sel, 64'd0};
                    job.count = i_in.masked ? CNT_W'(6) : CNT_W'(2);
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open <= 1'b0;
            r_bytes_left <= '0;
            r_key_store  <= '0;
            r_mask_on    <= 1'b0;
            r_key_phase  <= 2'd0;
        end else if (accept) begin
            r_frame_open <= n_frame_open;
            r_bytes_left <= n_bytes_left;
            r_key_store  <= n_key_store;
            r_mask_on    <= n_mask_on;
            r_key_phase  <= n_key_phase;
        end
    end

endmodule

### design/wsfe_queue.sv
// ----------------------------------------------------------------------------
// wsfe_queue
// Short job queue between the front and the serializer.
// ----------------------------------------------------------------------------
module wsfe_queue #(
    parameter int DEPTH = wsfe_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  wsfe_pkg::t_job i_push_job,
    output logic           o_pop_valid,
    input  logic           i_pop,
    output wsfe_pkg::t_job o_pop_job
);
    import wsfe_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    t_job              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_QW-1:0] r_count;
    logic              push, pop;

    assign o_push_ready = (r_count != CNT_QW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_QW'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_QW'(1);
            end
        end
    end

endmodule

### design/wsfe_back.sv
// ----------------------------------------------------------------------------
// wsfe_back
// Byte serializer: loads one job and shifts its bytes out onto the wire
// channel, one per accepted output request.
// ----------------------------------------------------------------------------
module wsfe_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    output logic           o_job_pop,
    input  wsfe_pkg::t_job i_job,
    wsfe_out_if.source     o_out
);
    import wsfe_pkg::*;

    logic [JOB_W-1:0] r_bytes;
    logic [CNT_W-1:0] r_count;
    logic             r_frame_end;
    logic [ERR_W-1:0] r_err;
    logic             fire;
    logic             take;

    // output register drives the channel
    assign o_out.valid     = (r_count != '0);
    assign o_out.out_byte  = r_bytes[JOB_W-1 -: 8];
    assign o_out.last      = (r_count == CNT_W'(1));
    assign o_out.frame_end = (r_count == CNT_W'(1)) && r_frame_end;
    assign o_out.error     = r_err;

    assign fire      = o_out.valid && o_out.ready;
    assign take      = (r_count == '0) || ((r_count == CNT_W'(1)) && o_out.ready);
    assign o_job_pop = take && i_job_valid;

    // payload of the current job
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_bytes     <= i_job.bytes;
            r_frame_end <= i_job.frame_end;
            r_err       <= i_job.err;
        end else if (fire) begin
            r_bytes <= {r_bytes[JOB_W-9:0], 8'd0};
        end
    end

    // bytes left in the current job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (o_job_pop) begin
            r_count <= i_job.count;
        end else if (fire) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

endmodule

### design/websocket_frame_encoder_core.sv
// Path: the job of an accepted request is written into the job queue, then loaded
// into the serializer registers, which drive its first wire byte.
// Throughput: one payload request per cycle while the output is ready; a start
// request holds the byte serializer until all bytes of its job (1 to 14) are sent.
// The front keeps accepting while the job queue has room, so a stalled output
// backs up into the queue before the input sees ready drop.
// Reset: synchronous, active low; clears the frame state, the queue and the output.
// ----------------------------------------------------------------------------
// websocket_frame_encoder_core
// Websocket frame encoder: header checks and framing in front, queue, byte
// serializer at the back.
// ----------------------------------------------------------------------------
module websocket_frame_encoder_core #(
    parameter int QUEUE_DEPTH = wsfe_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wsfe_in_if.sink     i_in,
    wsfe_out_if.source  o_out
);
    import wsfe_pkg::*;

    logic push_valid, push_ready;
    logic pop_valid,  pop;
    t_job push_job,   pop_job;

    // request classification and frame state
    wsfe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_job   (push_job)
    );

    // job queue
    wsfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_job   (push_job),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_pop_job    (pop_job)
    );

    // byte serializer
    wsfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (pop_valid),
        .o_job_pop   (pop),
        .i_job       (pop_job),
        .o_out       (o_out)
    );

endmodule

### design/wsfe_checker.sv
// ----------------------------------------------------------------------------
// wsfe_checker
// Port-level checks on the encoder output channel, bound to the top level.
// ----------------------------------------------------------------------------
module wsfe_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [7:0]             i_out_byte,
    input logic                   i_out_last,
    input logic                   i_out_frame_end,
    input logic [wsfe_pkg::ERR_W-1:0] i_out_error
);
    import wsfe_pkg::*;

    // output stays idle right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // an error request is a single zero byte that closes nothing
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_error != ERR_NONE)) |->
            (i_out_last && !i_out_frame_end && (i_out_byte == 8'd0)))
        else $error("error request with wrong shape");

    // frame end only on the final byte of a request
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_frame_end) |-> i_out_last)
        else $error("frame end without last");

    // stalled byte holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_byte) && $stable(i_out_last) &&
             $stable(i_out_frame_end) && $stable(i_out_error)))
        else $error("stalled output changed");

endmodule

bind websocket_frame_encoder_core wsfe_checker u_wsfe_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_byte      (o_out.out_byte),
    .i_out_last      (o_out.last),
    .i_out_frame_end (o_out.frame_end),
    .i_out_error     (o_out.error)
);
